// File: rtl/arw_pkg.sv
// ----------------------------------------------------------------------------
// arw_pkg: anti-replay window shared definitions
// transaction types, operation codes and default sizes
// ----------------------------------------------------------------------------
package arw_pkg;

  localparam int unsigned SeqW = 64;
  localparam int unsigned ArwWindowBits = 256;

  typedef enum logic {
    OpCheck = 1'b0,
    OpMark  = 1'b1
  } arw_op_e;

  typedef struct packed {
    arw_op_e         op;
    logic [SeqW-1:0] seq;
  } arw_in_t;

  typedef struct packed {
    logic replay;
    logic marked;
  } arw_out_t;

endpackage

// File: rtl/arw_in_reg.sv
// ----------------------------------------------------------------------------
// arw_in_reg: input register
// holds one incoming transaction until the window stage takes it
// ----------------------------------------------------------------------------
module arw_in_reg
  import arw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  arw_in_t in_item_i,
  output logic    item_valid_o,
  output arw_in_t item_o,
  input  logic    take_i
);

  logic    valid_q, valid_d;
  arw_in_t item_q;
  logic    load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: rtl/arw_window.sv
// ----------------------------------------------------------------------------
// arw_window: window state and result register
// checks or marks one sequence number per cycle, while the result side is ready, against the bitmap
// ----------------------------------------------------------------------------
module arw_window
  import arw_pkg::*;
#(
  parameter int unsigned WINDOW_BITS = ArwWindowBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     item_valid_i,
  input  arw_in_t  item_i,
  output logic     take_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output arw_out_t out_item_o
);

  localparam int unsigned IdxW = $clog2(WINDOW_BITS);
  localparam logic [SeqW-1:0] WinSize = SeqW'(WINDOW_BITS);

  logic [SeqW-1:0]        highest_q, highest_d;
  logic [WINDOW_BITS-1:0] bits_q, bits_d;
  logic                   out_valid_q, out_valid_d;
  arw_out_t               out_item_q, out_item_d;

  logic [SeqW-1:0]        fwd_dist, age;
  logic                   seq_zero, newer, too_old, far;
  logic [IdxW-1:0]        age_idx;
  logic [WINDOW_BITS-1:0] shifted;

  assign take_o      = item_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_d = take_o || (out_valid_q && !out_ready_i);

  assign seq_zero = (item_i.seq == '0);
  assign newer    = (item_i.seq > highest_q);
  assign fwd_dist = item_i.seq - highest_q;
  assign age      = highest_q - item_i.seq;
  assign too_old  = !newer && (age >= WinSize);
  assign far      = (fwd_dist >= WinSize);
  assign age_idx  = age[IdxW-1:0];
  assign shifted  = bits_q << fwd_dist[IdxW-1:0];

  always_comb begin
    highest_d  = highest_q;
    bits_d     = bits_q;
    out_item_d = '0;
    case (item_i.op)
      OpCheck: begin
        if (seq_zero || too_old) begin
          out_item_d.replay = 1'b1;
        end else if (!newer) begin
          out_item_d.replay = bits_q[age_idx];
        end
      end
      OpMark: begin
        if (!seq_zero && !too_old) begin
          out_item_d.marked = 1'b1;
          if (newer) begin
            // window slides up to the new number, which lands on bit 0
            bits_d    = far ? '0 : shifted;
            bits_d[0] = 1'b1;
            highest_d = item_i.seq;
          end else begin
            bits_d[age_idx] = 1'b1;
          end
        end
      end
      default: begin
        out_item_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      highest_q   <= '0;
      bits_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        highest_q <= highest_d;
        bits_q    <= bits_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: rtl/anti_replay_window_core.sv
// ----------------------------------------------------------------------------
// anti_replay_window_core: sliding window anti-replay filter
// keeps the highest marked sequence number and a bitmap of the window below it
// ----------------------------------------------------------------------------
// Each input transaction is a check (replay query, state unchanged) or a mark
// (record the number as received) and gives exactly one result transaction.
// The block takes one transaction per clock while the output side is ready: a
// transaction is captured in the input register, evaluated against the window
// state while it sits there, and its result is written to the output register
// when the window stage takes it and held until taken. A result is offered
// once its transaction has passed the input and output registers, and
// throughput is one per cycle while the output side is ready. The cycle time
// is set by the 64-bit age/distance subtract feeding the WINDOW_BITS-wide
// barrel shift and bit select of the bitmap. Sequence number zero always reads
// as a replay and is never marked; marks older than the window are dropped
// with marked low.
// ----------------------------------------------------------------------------
module anti_replay_window_core
  import arw_pkg::*;
#(
  parameter int unsigned WINDOW_BITS = ArwWindowBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  // input transactions
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  arw_in_t  in_item_i,
  // result transactions
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output arw_out_t out_item_o
);

  // staged transaction between input register and window stage
  logic    item_valid;
  arw_in_t item;
  logic    take;

  // input register, parts the upstream handshake from the evaluation
  arw_in_reg u_arw_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .take_i       (take)
  );

  // window state, single-pass evaluation and result register
  arw_window #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_arw_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

// File: rtl/arw_checker.sv
// ----------------------------------------------------------------------------
// arw_checker: port-level checks for the anti-replay window
// bound to the top level
// ----------------------------------------------------------------------------
module arw_checker
  import arw_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input arw_out_t out_item_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // a result never reports a replay and a mark together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.replay && out_item_o.marked))
    else $error("replay and marked both set");

  // input only backs up behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // a fresh result must trace back to an accepted input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching input transaction");

endmodule

bind anti_replay_window_core arw_checker u_arw_checker (.*);

// File: sim/anti_replay_window_core_tb.sv
// ----------------------------------------------------------------------------
// anti_replay_window_core_tb: self-checking bench for the anti-replay window
// drives check and mark transactions with bursty input and a stalling result
// side, predicts every result from a local window model and compares fields
// ----------------------------------------------------------------------------
module anti_replay_window_core_tb;
  import arw_pkg::*;

  localparam int unsigned WinBits = ArwWindowBits;
  localparam int unsigned WinIdxW = $clog2(WinBits);
  localparam logic [SeqW-1:0] SeqMax = '1;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  arw_in_t  in_item = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  arw_out_t out_item;

  anti_replay_window_core #(
    .WINDOW_BITS(WinBits)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // transactions waiting to be driven, results waiting to arrive
  arw_in_t  stim_q[$];
  arw_out_t result_q[$];

  // local copy of the window state
  logic [SeqW-1:0]    win_top = '0;
  logic [WinBits-1:0] win_map = '0;

  int unsigned err_cnt = 0;
  int unsigned n_check = 0, n_replay = 0, n_mark = 0, n_ignored = 0;
  int unsigned n_shift = 0, n_clear = 0;
  bit          in_taken = 1'b0;

  function automatic arw_out_t window_step(arw_in_t it);
    arw_out_t        res;
    logic [SeqW-1:0] age;
    logic [SeqW-1:0] fwd_dist;
    res = '0;
    if (it.op == OpCheck) begin
      n_check++;
      if (it.seq == '0) begin
        res.replay = 1'b1;
      end else if (it.seq > win_top) begin
        res.replay = 1'b0;
      end else begin
        // age as a difference, never as seq + window
        age = win_top - it.seq;
        if (age >= WinBits) res.replay = 1'b1;
        else res.replay = win_map[age[WinIdxW-1:0]];
      end
      if (res.replay) n_replay++;
    end else begin
      n_mark++;
      if (it.seq == '0) begin
        n_ignored++;
      end else if (it.seq <= win_top && (win_top - it.seq) >= WinBits) begin
        // older than the window, dropped
        n_ignored++;
      end else begin
        if (it.seq > win_top) begin
          fwd_dist = it.seq - win_top;
          if (fwd_dist >= WinBits) begin
            win_map = '0;
            n_clear++;
          end else begin
            win_map = win_map << fwd_dist;
            n_shift++;
          end
          win_top = it.seq;
        end
        age = win_top - it.seq;
        win_map[age[WinIdxW-1:0]] = 1'b1;
        res.marked = 1'b1;
      end
    end
    return res;
  endfunction

  // monitor: results are checked before the new input is predicted, so a
  // result can never be matched against its own transaction on the same edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result transaction with nothing expected: replay %0b marked %0b",
                 out_item.replay, out_item.marked);
          err_cnt++;
        end else begin
          if (out_item.replay !== result_q[0].replay) begin
            $error("replay: expected %0b, actual %0b", result_q[0].replay, out_item.replay);
            err_cnt++;
          end
          if (out_item.marked !== result_q[0].marked) begin
            $error("marked: expected %0b, actual %0b", result_q[0].marked, out_item.marked);
            err_cnt++;
          end
          void'(result_q.pop_front());
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) result_q.push_back(window_step(in_item));
    end
  end

  // driver: bursts of random length separated by random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          in_item <= stim_q.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side stall pattern: modes picked for random stretches
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(32, 200);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        // ready high, then low, in a repeating pattern
        out_ready <= ((rx_tick % 5) < 2);
      end
    endcase
  end

  // stimulus generation mirrors the highest marked number to aim near the window
  logic [SeqW-1:0] gen_top = '0;
  bit              top_marks_ok = 1'b0;

  task automatic push_item(arw_op_e op, logic [SeqW-1:0] seq);
    arw_in_t it;
    it.op = op;
    it.seq = seq;
    stim_q.push_back(it);
    if (op == OpMark && seq > gen_top) gen_top = seq;
  endtask

  task automatic wait_drained();
    while (stim_q.size() != 0 || (in_valid && !in_taken) || result_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic push_random(int unsigned count);
    int unsigned     r;
    arw_op_e         op;
    logic [SeqW-1:0] seq;
    for (int unsigned i = 0; i < count; i++) begin
      op = ($urandom_range(0, 99) < 45) ? OpMark : OpCheck;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        seq = '0;
      end else if (r < 8) begin
        seq = {$urandom(), $urandom()};
      end else if (r < 12) begin
        seq = SeqMax - $urandom_range(0, WinBits + 40);
        // near the top of the range only checks, until the last stretch
        if (!top_marks_ok) op = OpCheck;
      end else if (r < 50) begin
        seq = gen_top - $urandom_range(0, WinBits + 20);
      end else if (r < 78) begin
        seq = gen_top + $urandom_range(1, 8);
      end else if (r < 94) begin
        seq = gen_top + $urandom_range(1, WinBits + 40);
      end else begin
        seq = gen_top - $urandom_range(WinBits + 1, 100000);
      end
      push_item(op, seq);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero, first mark, re-mark, window edges, shift out, exact clear
    push_item(OpCheck, '0);
    push_item(OpMark, '0);
    push_item(OpCheck, 64'd1);
    push_item(OpMark, 64'd1);
    push_item(OpCheck, 64'd1);
    push_item(OpMark, 64'd1);
    push_item(OpMark, SeqW'(WinBits));
    push_item(OpCheck, 64'd1);
    push_item(OpCheck, 64'd2);
    push_item(OpMark, SeqW'(WinBits + 1));
    push_item(OpCheck, 64'd1);
    push_item(OpMark, 64'd1);
    push_item(OpMark, SeqW'(2 * WinBits + 1));
    push_item(OpCheck, SeqW'(WinBits + 1));
    push_item(OpCheck, SeqW'(2 * WinBits + 1));
    wait_drained();

    push_random(850);
    // hold the sender off until every result is back
    wait_drained();
    push_random(700);
    top_marks_ok = 1'b1;
    push_random(150);

    // directed: top of the sequence range and old numbers far below it
    push_item(OpMark, SeqMax);
    push_item(OpCheck, SeqMax);
    push_item(OpCheck, SeqMax - (WinBits - 1));
    push_item(OpMark, SeqMax - (WinBits - 1));
    push_item(OpCheck, SeqMax - (WinBits - 1));
    push_item(OpCheck, SeqMax - WinBits);
    push_item(OpMark, SeqMax - WinBits);
    push_item(OpCheck, 64'd1);
    push_item(OpCheck, '0);
    wait_drained();

    // nothing more should come out after the last result
    repeat (20) @(negedge clk_i);

    $display("covered %0d checks (%0d replays) and %0d marks (%0d dropped)",
             n_check, n_replay, n_mark, n_ignored);
    $display("window moved by shift %0d times and cleared by a jump %0d times",
             n_shift, n_clear);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
rtl/arw_pkg.sv
rtl/arw_in_reg.sv
rtl/arw_window.sv
rtl/anti_replay_window_core.sv
rtl/arw_checker.sv
sim/anti_replay_window_core_tb.sv
